@@ hdl/tssc_pkg.sv @@
// ----------------------------------------------------------------------------
// tssc_pkg: shared definitions for the tempo step sequencer clock
// Widths, reset values, register indexes, state codes and shared-unit types.
// ----------------------------------------------------------------------------
`default_nettype none

package tssc_pkg;

  localparam int SAMPLE_RATE = 8000;
  localparam int MIN_STEPS   = 8;
  localparam int MAX_STEPS   = 32;

  localparam int ACC_W      = 22;
  localparam int STEP_W     = 6;
  localparam int BPM_W      = 16;
  localparam int RES_W      = 8;
  localparam int LEN_W      = 8;
  localparam int PLEN_W     = 7;
  localparam int DEN_W      = BPM_W + RES_W;
  localparam int ALU_W      = DEN_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // samples per minute, the dividend of the period
  localparam int DIVIDEND = SAMPLE_RATE * 60;
  localparam int DVD_W    = $clog2(DIVIDEND + 1);
  localparam int CNT_W    = $clog2(DVD_W);

  localparam int RST_BPM    = 120;
  localparam int RST_RES    = 4;
  localparam int RST_LEN    = 16;
  localparam int RST_PERIOD = DIVIDEND / (RST_BPM * RST_RES);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMPO = 2'd0,
    REG_RES   = 2'd1,
    REG_LEN   = 2'd2
  } cfg_idx_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_INC  = 7'b0000010,
    S_CMP  = 7'b0000100,
    S_STEP = 7'b0001000,
    S_DONE = 7'b0010000,
    S_MUL  = 7'b0100000,
    S_DIV  = 7'b1000000
  } state_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic [ALU_W-1:0]   a;
    logic [ALU_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0]   res;
    logic               borrow;  // sub: a < b
  } alu_rsp_t;

  // raise to the minimum first, then lower to the maximum
  function automatic logic [PLEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] t;
    t = v;
    if (t < LEN_W'(MIN_STEPS)) t = LEN_W'(MIN_STEPS);
    if (t > LEN_W'(MAX_STEPS)) t = LEN_W'(MAX_STEPS);
    return t[PLEN_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/tssc_if.sv @@
// ----------------------------------------------------------------------------
// tssc_if: channel interfaces of the tempo step sequencer clock
// Tick input, step result and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface tssc_in_if import tssc_pkg::*; ();
  logic valid;
  logic ready;
  logic sample_tick;
  modport source (output valid, output sample_tick, input ready);
  modport sink   (input valid, input sample_tick, output ready);
endinterface

interface tssc_out_if import tssc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] current_step;
  logic              step_advanced;
  modport source (output valid, output current_step, output step_advanced, input ready);
  modport sink   (input valid, input current_step, input step_advanced, output ready);
endinterface

interface tssc_cfg_if import tssc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/tempo_step_sequencer_clock_core.sv @@
// ----------------------------------------------------------------------------
// tempo_step_sequencer_clock_core: tempo-driven step counter
// A tick passes through S_INC, S_CMP and, when the step advances, S_STEP
//   to S_DONE, which loads the output register once it is free; an empty tick
//   goes from S_INC to S_DONE. The next tick is taken once back in idle.
// A tempo or resolution write starts a restoring division (S_MUL, S_DIV),
//   one quotient bit per cycle through the shared adder.
// Reset (rst_n low, synchronous): registers 120 bpm / 4 / 16, step and
//   accumulator 0, period preloaded; no division runs after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tempo_step_sequencer_clock_core import tssc_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  tssc_in_if.sink     in_if,
  tssc_out_if.source  out_if,
  tssc_cfg_if.sink    cfg_if
);

  state_t              state_r, state_nxt;
  logic [BPM_W-1:0]    bpm_r, bpm_nxt;
  logic [RES_W-1:0]    res_r, res_nxt;
  logic [PLEN_W-1:0]   plen_r, plen_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [ACC_W-1:0]    spp_r, spp_nxt;      // samples per step
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                tick_r, tick_nxt;
  logic                adv_r, adv_nxt;      // advance flag of the tick in work
  // divider
  logic [DEN_W-1:0]    den_r, den_nxt;
  logic [DEN_W-1:0]    rem_r, rem_nxt;
  logic [DVD_W-1:0]    q_r, q_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [STEP_W-1:0]   out_step_r, out_step_nxt;
  logic                out_adv_r, out_adv_nxt;

  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;

  logic                in_xfer, cfg_xfer;
  logic [RES_W-1:0]    res_eff;
  logic [DEN_W-1:0]    prod;
  logic [ALU_W-1:0]    trial;
  logic [PLEN_W-1:0]   len_new;
  logic [PLEN_W-1:0]   step_inc;
  logic                qbit;

  tssc_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // ticks take priority; a config write waits for a cycle without one
  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = (state_r == S_IDLE) && !in_if.valid;
  assign in_xfer      = in_if.valid && in_if.ready;
  assign cfg_xfer     = cfg_if.valid && cfg_if.ready;

  assign out_if.valid         = out_valid_r;
  assign out_if.current_step  = out_step_r;
  assign out_if.step_advanced = out_adv_r;

  assign res_eff  = (res_r == '0) ? RES_W'(1) : res_r;
  assign prod     = DEN_W'(bpm_r) * DEN_W'(res_eff);
  assign trial    = {rem_r, q_r[DVD_W-1]};
  assign len_new  = clamp_len(cfg_if.data[LEN_W-1:0]);
  assign step_inc = alu_rsp.res[PLEN_W-1:0];
  assign qbit     = !alu_rsp.borrow;

  always_comb begin
    state_nxt     = state_r;
    bpm_nxt       = bpm_r;
    res_nxt       = res_r;
    plen_nxt      = plen_r;
    acc_nxt       = acc_r;
    spp_nxt       = spp_r;
    step_nxt      = step_r;
    tick_nxt      = tick_r;
    adv_nxt       = adv_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_step_nxt  = out_step_r;
    out_adv_nxt   = out_adv_r;
    alu_req.op    = ALU_ADD;
    alu_req.a     = ALU_W'(acc_r);
    alu_req.b     = ALU_W'(1);

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          tick_nxt  = in_if.sample_tick;
          state_nxt = S_INC;
        end else if (cfg_xfer) begin
          case (cfg_if.index)
            REG_TEMPO: begin
              bpm_nxt   = cfg_if.data[BPM_W-1:0];
              state_nxt = S_MUL;
            end
            REG_RES: begin
              res_nxt   = cfg_if.data[RES_W-1:0];
              state_nxt = S_MUL;
            end
            REG_LEN: begin
              plen_nxt = len_new;
              if ({1'b0, step_r} >= len_new) step_nxt = '0;
            end
            default: ;  // unknown index: ignored
          endcase
        end
      end
      S_INC: begin
        // accumulator + 1, wraps at ACC_W bits
        if (tick_r) begin
          acc_nxt   = alu_rsp.res[ACC_W-1:0];
          state_nxt = S_CMP;
        end else begin
          adv_nxt   = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_CMP: begin
        // reached the period: take one period off, keep the remainder
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(acc_r);
        alu_req.b  = ALU_W'(spp_r);
        if (!alu_rsp.borrow) begin
          acc_nxt   = alu_rsp.res[ACC_W-1:0];
          state_nxt = S_STEP;
        end else begin
          adv_nxt   = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_STEP: begin
        alu_req.a = ALU_W'(step_r);
        step_nxt  = (step_inc >= plen_r) ? '0 : step_inc[STEP_W-1:0];
        adv_nxt   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // the output register is only touched once it is free
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_step_nxt  = step_r;
          out_adv_nxt   = adv_r;
          state_nxt     = S_IDLE;
        end
      end
      S_MUL: begin
        den_nxt   = (prod == '0) ? DEN_W'(1) : prod;
        rem_nxt   = '0;
        q_nxt     = DVD_W'(DIVIDEND);
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        alu_req.op = ALU_SUB;
        alu_req.a  = trial;
        alu_req.b  = ALU_W'(den_r);
        rem_nxt    = qbit ? alu_rsp.res[DEN_W-1:0] : trial[DEN_W-1:0];
        q_nxt      = {q_r[DVD_W-2:0], qbit};
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          spp_nxt   = ACC_W'(q_nxt);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bpm_r       <= BPM_W'(RST_BPM);
      res_r       <= RES_W'(RST_RES);
      plen_r      <= clamp_len(LEN_W'(RST_LEN));
      acc_r       <= '0;
      spp_r       <= ACC_W'(RST_PERIOD);
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bpm_r       <= bpm_nxt;
      res_r       <= res_nxt;
      plen_r      <= plen_nxt;
      acc_r       <= acc_nxt;
      spp_r       <= spp_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tick_r     <= tick_nxt;
    adv_r      <= adv_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    cnt_r      <= cnt_nxt;
    out_step_r <= out_step_nxt;
    out_adv_r  <= out_adv_nxt;
  end

  // step index always inside the pattern
  a_step_in_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, step_r} < plen_r)
    else $error("step index outside pattern length");

  // a result only appears from the completion state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside completion state");

  // tempo or resolution write starts the period computation
  a_cfg_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_if.valid && cfg_if.ready &&
     (cfg_if.index == REG_TEMPO || cfg_if.index == REG_RES)) |=> state_r == S_MUL)
    else $error("period recompute not started");

  // no tick transfer while the divider runs
  a_no_tick_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV || state_r == S_MUL) |-> !(in_if.valid && in_if.ready))
    else $error("tick taken during division");

endmodule

`default_nettype wire

@@ hdl/tssc_alu.sv @@
// ----------------------------------------------------------------------------
// tssc_alu: shared add/subtract unit
// One adder serves accumulator, step and restoring-division updates.
// ----------------------------------------------------------------------------
`default_nettype none

module tssc_alu import tssc_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [ALU_W:0] sum;
  logic [ALU_W-1:0] b_op;

  assign b_op = (req.op == ALU_SUB) ? ~req.b : req.b;
  assign sum  = {1'b0, req.a} + {1'b0, b_op} + {{ALU_W{1'b0}}, (req.op == ALU_SUB)};

  assign rsp.res    = sum[ALU_W-1:0];
  assign rsp.borrow = (req.op == ALU_SUB) & ~sum[ALU_W];

endmodule

`default_nettype wire

@@ bench/tssc_step_checker.sv @@
// ----------------------------------------------------------------------------
// tssc_step_checker: scoreboard for the tempo step sequencer clock
// Tracks register writes and tick transfers, predicts each step result and
// compares it with the result transfers in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tssc_step_checker import tssc_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  tssc_in_if   in_ch,
  tssc_out_if  out_ch,
  tssc_cfg_if  cfg_ch,
  output int   n_errors,
  output int   n_pending
);

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic              advanced;
  } step_result_t;

  localparam int PRINT_CAP = 100;

  // shadow copy of the sequencer
  logic [BPM_W-1:0]  bpm_q;
  logic [RES_W-1:0]  res_q;
  logic [PLEN_W-1:0] len_q;
  logic [ACC_W-1:0]  acc_q;
  logic [ACC_W-1:0]  period_q;
  logic [STEP_W-1:0] step_q;

  step_result_t owed_steps[$];
  int           err_cnt = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_cnt < PRINT_CAP)
      $display("[%0t] step check: %s got %0d want %0d", $time, what, got, want);
    err_cnt++;
  endtask

  function automatic logic [ACC_W-1:0] period_for(input logic [BPM_W-1:0] bpm,
                                                  input logic [RES_W-1:0] res);
    logic [RES_W-1:0] r;
    logic [DEN_W-1:0] den;
    r   = (res == '0) ? RES_W'(1) : res;
    den = bpm * r;
    if (den == '0) den = DEN_W'(1);
    return ACC_W'(DIVIDEND / den);
  endfunction

  function automatic logic [PLEN_W-1:0] fit_length(input logic [LEN_W-1:0] v);
    if (v < LEN_W'(MIN_STEPS)) return PLEN_W'(MIN_STEPS);
    if (v > LEN_W'(MAX_STEPS)) return PLEN_W'(MAX_STEPS);
    return v[PLEN_W-1:0];
  endfunction

  function automatic step_result_t advance_sequencer(input logic tick);
    step_result_t r;
    r.advanced = 1'b0;
    if (tick) begin
      acc_q = acc_q + 1'b1;
      if (acc_q >= period_q) begin
        // subtract one period only, remainder carries
        acc_q = acc_q - period_q;
        if ({1'b0, step_q} + 1'b1 >= len_q) step_q = '0;
        else step_q = step_q + 1'b1;
        r.advanced = 1'b1;
      end
    end
    r.step = step_q;
    return r;
  endfunction

  always @(posedge clk) begin
    step_result_t want;
    if (!rst_n) begin
      bpm_q    = BPM_W'(120);
      res_q    = RES_W'(4);
      len_q    = fit_length(LEN_W'(16));
      acc_q    = '0;
      step_q   = '0;
      period_q = period_for(bpm_q, res_q);
      owed_steps.delete();
    end else begin
      // a result leaving now belongs to an older tick than one entering now
      if (out_ch.valid && out_ch.ready) begin
        if (owed_steps.size() == 0) begin
          report_mismatch("result with nothing owed, step", int'(out_ch.current_step), -1);
        end else begin
          want = owed_steps.pop_front();
          if (out_ch.current_step !== want.step)
            report_mismatch("current_step", int'(out_ch.current_step), int'(want.step));
          if (out_ch.step_advanced !== want.advanced)
            report_mismatch("step_advanced", int'(out_ch.step_advanced), int'(want.advanced));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_TEMPO: begin
            bpm_q    = cfg_ch.data[BPM_W-1:0];
            period_q = period_for(bpm_q, res_q);
          end
          REG_RES: begin
            res_q    = cfg_ch.data[RES_W-1:0];
            period_q = period_for(bpm_q, res_q);
          end
          REG_LEN: begin
            len_q = fit_length(cfg_ch.data[LEN_W-1:0]);
            if ({1'b0, step_q} >= len_q) step_q = '0;
          end
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        owed_steps.push_back(advance_sequencer(in_ch.sample_tick));
    end
    n_pending <= owed_steps.size();
    n_errors  <= err_cnt;
  end

endmodule

@@ bench/tempo_step_sequencer_clock_core_test.sv @@
// ----------------------------------------------------------------------------
// tempo_step_sequencer_clock_core_test: top of the step sequencer bench
// Drives tick, result and register channels with random gaps and stalls;
// a directed opener hits the corner cases, then random tempo phases follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tempo_step_sequencer_clock_core_test import tssc_pkg::*;;

  localparam int LIMIT_CYCLES = 600000;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int RANDOM_TICKS = 1420;
  localparam int SETTLE       = 12;    // a little over one tick's latency

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic clk;
  logic rst_n;

  tssc_in_if  in_ch();
  tssc_out_if out_ch();
  tssc_cfg_if cfg_ch();

  int err_total;
  int results_owed;
  int cycle_cnt;
  bit hold_req = 1'b0;

  tempo_step_sequencer_clock_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  tssc_step_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .n_errors  (err_total),
    .n_pending (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a correct run ends far below this.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Mostly back-to-back, often short, now and then long.
  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One tick transfer. Valid stays high across back-to-back ticks so it is
  // never dropped and raised in the same step.
  task automatic send_tick(input logic tick);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sample_tick <= tick;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    repeat ($urandom_range(1, 4)) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Every tick gives a result, so once nothing is owed the block is idle.
  // The first edge lets the owed count catch the last tick transfer.
  task automatic wait_drained();
    do @(posedge clk); while (results_owed != 0);
  endtask

  // Receiver: random ready with short and long stalls; on request it holds
  // off for a long stretch so the block backs up and stalls the ticks.
  initial begin
    int k;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        k = $urandom_range(0, 99);
        if (k < 55) begin
          out_ch.ready <= 1'b1;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end else if (k < 95) begin
          out_ch.ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_ch.ready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int         ticks_sent;
    int         burst;
    int         mode;
    int         rot;
    int         s;
    int         p;
    int         b;
    bit         first;
    logic [15:0] bpm;
    logic [7:0]  spq;
    logic [7:0]  plen;
    cfg_idx_t    order [3];
    cfg_idx_t    idx;
    logic [7:0]  len_edges [6];

    order     = '{REG_TEMPO, REG_RES, REG_LEN};
    len_edges = '{8'd0, 8'd255, 8'd7, 8'd33, 8'd8, 8'd32};

    in_ch.valid       <= 1'b0;
    in_ch.sample_tick <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= REG_TEMPO;
    cfg_ch.data       <= '0;
    rst_n             <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    // reset tempo: period 1000, nothing advances; includes an empty tick
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    in_ch.valid <= 1'b0;
    wait_drained();

    // divisor beyond the dividend: zero period, step on every non-empty tick;
    // upper data bits set on the 8-bit registers, length 0 clamps up to min
    write_reg(REG_TEMPO, 16'hFFFF);
    write_reg(REG_RES, 16'hFFFF);
    write_reg(REG_LEN, 16'h0000);
    for (int i = 0; i < 9; i++) send_tick(i != 4);
    in_ch.valid <= 1'b0;
    wait_drained();

    // 255 clamps down to max; walk the step up to 8, then shrink the length to 8
    write_reg(REG_LEN, 16'h00FF);
    for (int i = 0; i < 8; i++) send_tick(1'b1);
    in_ch.valid <= 1'b0;
    wait_drained();
    write_reg(REG_LEN, 16'h0008);

    // the zero period let the accumulator climb; a short period now has to
    // catch up, stepping on each tick
    write_reg(REG_RES, 16'h0004);
    write_reg(REG_TEMPO, 16'd60000);
    for (int i = 0; i < 4; i++) send_tick(1'b1);
    in_ch.valid <= 1'b0;
    wait_drained();

    // write to an unmapped index must be ignored
    write_reg(REG_SPARE, 16'hA5A5);

    // zero tempo and zero resolution: divisor forced to one
    write_reg(REG_TEMPO, 16'h0000);
    write_reg(REG_RES, 16'h0000);
    send_tick(1'b1);
    send_tick(1'b1);
    in_ch.valid <= 1'b0;
    wait_drained();

    // --- random tempo phases ---
    ticks_sent = 0;
    first      = 1'b1;
    while (ticks_sent < RANDOM_TICKS) begin
      mode = $urandom_range(0, 9);
      case (mode)
        0: begin
          bpm = '0;
          spq = 8'($urandom);
        end
        1: begin
          bpm = 16'hFFFF;
          spq = 8'hFF;
        end
        2: begin
          bpm = 16'($urandom_range(1, 65535));
          spq = '0;
        end
        3: begin
          bpm = 16'($urandom);
          spq = 8'($urandom);
        end
        default: begin
          // aim at a short period so steps come often
          s = $urandom_range(1, 8);
          p = $urandom_range(1, 12);
          b = DIVIDEND / (p * s);
          if (b > 65535) b = 65535;
          bpm = 16'(b);
          spq = 8'(s);
        end
      endcase
      if ($urandom_range(0, 3) == 0) plen = len_edges[$urandom_range(0, 5)];
      else plen = 8'($urandom_range(6, 34));

      // all three registers, in a rotating order
      rot = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) begin
        idx = order[(rot + k) % 3];
        case (idx)
          REG_TEMPO: write_reg(REG_TEMPO, bpm);
          REG_RES:   write_reg(REG_RES, {8'($urandom), spq});
          default:   write_reg(REG_LEN, {8'($urandom), plen});
        endcase
      end
      if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, 16'($urandom));

      if (first) begin
        // long phase under the receiver hold-off so the pipe fills up
        first    = 1'b0;
        hold_req = 1'b1;
        burst    = 80;
      end else if ($urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 3);
      end else begin
        burst = $urandom_range(10, 70);
      end

      for (int i = 0; i < burst; i++) begin
        send_tick($urandom_range(0, 9) != 0);
        ticks_sent++;
      end
      in_ch.valid <= 1'b0;
      wait_drained();
    end

    repeat (SETTLE) @(posedge clk);
    if (err_total == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
